### rtl/lsv_pkg.sv
// Package with shared types, constants and lookup tables for the log-softmax block.
package lsv_pkg;

    localparam int MAX_LEN_DEFAULT = 64;
    localparam int VAL_W = 16;
    localparam int SUM_W = 23;
    localparam int LN2_Q16 = 45426;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM,
        ST_LN,
        ST_OUT
    } lsv_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;     // write the accepted element and update the maximum
        logic clr_rd;    // restart the read pointer
        logic sum_step;  // issue one read and accumulate one exp term
        logic ln_start;  // compute ln of the finished sum
        logic out_step;  // issue one read for the output pass
        logic clear;     // return count, maximum and sum to reset values
    } lsv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rd_done;   // every stored element has been read
        logic sum_idle;  // no exp term is still in flight
        logic ln_done;   // ln result is ready
        logic out_idle;  // output pipeline and skid register are empty
        logic out_room;  // output side can take another read
    } lsv_sts_t;

    function automatic logic [16:0] exp_int(input logic [3:0] i);
        unique case (i)
            4'd0: exp_int = 17'd65536;
            4'd1: exp_int = 17'd24109;
            4'd2: exp_int = 17'd8869;
            4'd3: exp_int = 17'd3263;
            4'd4: exp_int = 17'd1200;
            4'd5: exp_int = 17'd442;
            4'd6: exp_int = 17'd162;
            4'd7: exp_int = 17'd60;
            4'd8: exp_int = 17'd22;
            4'd9: exp_int = 17'd8;
            4'd10: exp_int = 17'd3;
            4'd11: exp_int = 17'd1;
            default: exp_int = 17'd0;
        endcase
    endfunction

    function automatic logic [16:0] exp_hi(input logic [3:0] i);
        unique case (i)
            4'd0: exp_hi = 17'd65536;
            4'd1: exp_hi = 17'd61565;
            4'd2: exp_hi = 17'd57835;
            4'd3: exp_hi = 17'd54331;
            4'd4: exp_hi = 17'd51039;
            4'd5: exp_hi = 17'd47947;
            4'd6: exp_hi = 17'd45042;
            4'd7: exp_hi = 17'd42313;
            4'd8: exp_hi = 17'd39750;
            4'd9: exp_hi = 17'd37341;
            4'd10: exp_hi = 17'd35079;
            4'd11: exp_hi = 17'd32952;
            4'd12: exp_hi = 17'd30957;
            4'd13: exp_hi = 17'd29081;
            4'd14: exp_hi = 17'd27319;
            default: exp_hi = 17'd25664;
        endcase
    endfunction

    function automatic logic [16:0] exp_lo(input logic [3:0] i);
        unique case (i)
            4'd0: exp_lo = 17'd65536;
            4'd1: exp_lo = 17'd65280;
            4'd2: exp_lo = 17'd65026;
            4'd3: exp_lo = 17'd64772;
            4'd4: exp_lo = 17'd64520;
            4'd5: exp_lo = 17'd64268;
            4'd6: exp_lo = 17'd64018;
            4'd7: exp_lo = 17'd63768;
            4'd8: exp_lo = 17'd63520;
            4'd9: exp_lo = 17'd63272;
            4'd10: exp_lo = 17'd63025;
            4'd11: exp_lo = 17'd62780;
            4'd12: exp_lo = 17'd62535;
            4'd13: exp_lo = 17'd62291;
            4'd14: exp_lo = 17'd62048;
            default: exp_lo = 17'd61806;
        endcase
    endfunction

    function automatic logic [15:0] ln_tab(input logic [4:0] i);
        unique case (i)
            5'd0: ln_tab = 16'd0;
            5'd1: ln_tab = 16'd3973;
            5'd2: ln_tab = 16'd7719;
            5'd3: ln_tab = 16'd11262;
            5'd4: ln_tab = 16'd14624;
            5'd5: ln_tab = 16'd17821;
            5'd6: ln_tab = 16'd20870;
            5'd7: ln_tab = 16'd23783;
            5'd8: ln_tab = 16'd26573;
            5'd9: ln_tab = 16'd29248;
            5'd10: ln_tab = 16'd31818;
            5'd11: ln_tab = 16'd34292;
            5'd12: ln_tab = 16'd36675;
            5'd13: ln_tab = 16'd38975;
            5'd14: ln_tab = 16'd41196;
            5'd15: ln_tab = 16'd43345;
            default: ln_tab = 16'd45426;
        endcase
    endfunction

endpackage

### rtl/log_softmax_vector_top.sv
// Top level of the log-softmax vector block.
//
// Elements arrive on the s_ stream, one signed Q7.8 value per request, with
// s_tuser marking the final element of a vector. Up to MAX_LEN elements are
// stored; extra ones are dropped but a final flag still ends the vector.
// After the final element the block reads the store once to sum exp(x-max),
// computes ln of the sum, then reads the store again and emits
// one result per element on the m_ stream, m_tuser marking the last one.
// While loading, s_tready stays high. In the output pass each result walks
// a memory read, a subtract stage, the output register and its acceptance
// before the next read is issued.
// No input is taken until the last result of a vector has been delivered.
// A stall on m_tready simply holds the output register and the pass waits.
// Reset (aresetn low, synchronous) clears the count, maximum, sum and all
// valid bits; the element store needs no clearing.
module log_softmax_vector_top #(
    parameter int MAX_LEN = lsv_pkg::MAX_LEN_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic        s_tuser,   // [0] last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] log_prob
    output logic        m_tuser    // [0] last_res
);
    import lsv_pkg::*;

    lsv_cmd_t cmd;
    lsv_sts_t sts;

    lsv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_req   (s_tvalid && s_tready),
        .in_last  (s_tuser),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    lsv_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_value  (s_tdata),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_prob  (m_tdata),
        .out_last  (m_tuser)
    );
endmodule

### rtl/lsv_ctrl.sv
// Controller state machine that sequences the load, sum, ln and output passes.
module lsv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_req,
    input  logic              in_last,
    input  lsv_pkg::lsv_sts_t sts,
    output logic              in_ready,
    output lsv_pkg::lsv_cmd_t cmd
);
    import lsv_pkg::*;

    lsv_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_req && in_last) state_next = ST_SUM;
            end
            ST_SUM: begin
                if (sts.rd_done && sts.sum_idle) state_next = ST_LN;
            end
            ST_LN: begin
                if (sts.ln_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.rd_done && sts.out_idle) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                in_ready  = 1'b1;
                cmd.store = in_req;
                cmd.clr_rd = 1'b1;
            end
            ST_SUM: begin
                cmd.sum_step = !sts.rd_done;
                if (sts.rd_done && sts.sum_idle) begin
                    cmd.ln_start = 1'b1;
                    cmd.clr_rd = 1'b1;
                end
            end
            ST_LN: begin
                cmd.clr_rd = 1'b1;
            end
            ST_OUT: begin
                cmd.out_step = !sts.rd_done && sts.out_room;
                cmd.clear = sts.rd_done && sts.out_idle;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_no_store_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> state_reg == ST_LOAD) else $error("store outside load");
    a_sum_to_ln: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM && state_next == ST_LN) |-> sts.sum_idle)
        else $error("ln started with terms in flight");
    a_out_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && state_next == ST_LOAD) |-> sts.out_idle)
        else $error("left output pass early");
`endif
endmodule

### rtl/lsv_dp.sv
// Datapath: element memory, maximum, exp accumulation, ln unit and output stage.
module lsv_dp #(
    parameter int MAX_LEN = lsv_pkg::MAX_LEN_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsv_pkg::lsv_cmd_t cmd,
    input  logic [15:0]       in_value,
    output lsv_pkg::lsv_sts_t sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       out_prob,
    output logic              out_last
);
    import lsv_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [15:0]       mem [MAX_LEN];
    logic [CW-1:0]     cnt_reg;
    logic signed [15:0] max_reg;
    logic [CW-1:0]     rd_reg;
    logic [15:0]       rdata_reg;

    // Sum pipeline valid bits and data.
    logic              s1_v_reg, s2_v_reg, s3_v_reg;
    logic [15:0]       s2_d_reg;
    logic [32:0]       s2_p_reg;
    logic [33:0]       s3_p_reg;
    logic [SUM_W-1:0]  sum_reg;

    // Ln unit.
    logic [2:0]        ln_ph_reg;
    logic [21:0]       f_reg;
    logic [2:0]        k_reg;
    logic [15:0]       lt_reg;
    logic [16:0]       dif_reg;
    logic [34:0]       lp_reg;
    logic [19:0]       ln_reg;

    // Output pipeline.
    logic              o1_v_reg, o2_v_reg;
    logic              o1_l_reg, o2_l_reg;
    logic [24:0]       o2_q_reg;
    logic              sk_v_reg;
    logic [15:0]       sk_d_reg;
    logic              sk_l_reg;

    logic              rd_en;
    logic [15:0]       d_cur;

    assign rd_en = cmd.sum_step || cmd.out_step;
    assign d_cur = 16'(max_reg - $signed(rdata_reg));

    // Element memory with registered read.
    always_ff @(posedge aclk) begin
        if (cmd.store && cnt_reg < CW'(MAX_LEN)) begin
            mem[cnt_reg[AW-1:0]] <= in_value;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_reg[AW-1:0]];
        end
    end

    // Count, maximum and read pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            cnt_reg <= '0;
            max_reg <= 16'sh8000;
        end else if (cmd.store && cnt_reg < CW'(MAX_LEN)) begin
            cnt_reg <= cnt_reg + 1'b1;
            if ($signed(in_value) > max_reg) max_reg <= $signed(in_value);
        end
        if (!aresetn || cmd.clr_rd) begin
            rd_reg <= '0;
        end else if (rd_en) begin
            rd_reg <= rd_reg + 1'b1;
        end
    end

    // Exp term pipeline: table lookup, two multiplies, accumulate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            sum_reg  <= '0;
        end else begin
            s1_v_reg <= cmd.sum_step;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            if (cmd.clear) begin
                sum_reg <= '0;
            end else if (s3_v_reg) begin
                sum_reg <= sum_reg + SUM_W'((s3_p_reg + 34'd32768) >> 16);
            end
        end
        s2_d_reg <= d_cur;
        s2_p_reg <= (d_cur[15:8] >= 8'd12) ? 33'd0
                    : 33'(exp_int(d_cur[11:8])) * 33'(exp_hi(d_cur[7:4]));
        s3_p_reg <= 34'(17'((s2_p_reg + 33'd32768) >> 16)) * 34'(exp_lo(s2_d_reg[3:0]));
    end

    // Ln of the sum in a few phases: normalize, look up, multiply, add.
    logic [SUM_W-1:0] s_cl;
    logic [2:0]       p_sel;
    always_comb begin
        s_cl = (sum_reg < SUM_W'(65536)) ? SUM_W'(65536) : sum_reg;
        p_sel = 3'd0;
        for (int b = 17; b <= 22; b++) begin
            if (s_cl[b]) p_sel = 3'(b - 16);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ln_ph_reg <= '0;
        end else if (cmd.ln_start) begin
            ln_ph_reg <= 3'd1;
        end else if (ln_ph_reg != 3'd0 && ln_ph_reg != 3'd4) begin
            ln_ph_reg <= ln_ph_reg + 1'b1;
        end else if (cmd.clear) begin
            ln_ph_reg <= '0;
        end
        if (cmd.ln_start) begin
            f_reg <= 22'(s_cl << (3'd6 - p_sel));
            k_reg <= p_sel;
        end
        if (ln_ph_reg == 3'd1) begin
            lt_reg  <= ln_tab({1'b0, f_reg[21:18]});
            dif_reg <= 17'(ln_tab({1'b0, f_reg[21:18]} + 5'd1))
                       - 17'(ln_tab({1'b0, f_reg[21:18]}));
        end
        if (ln_ph_reg == 3'd2) begin
            lp_reg <= 35'(dif_reg) * 35'(f_reg[17:0]);
        end
        if (ln_ph_reg == 3'd3) begin
            ln_reg <= 20'(k_reg) * 20'(LN2_Q16) + 20'(lt_reg)
                      + 20'((lp_reg + 35'd131072) >> 18);
        end
    end

    // Output pipeline with a skid register at the port.
    logic o_take;
    assign o_take = !sk_v_reg || out_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o1_v_reg <= 1'b0;
            o2_v_reg <= 1'b0;
            sk_v_reg <= 1'b0;
        end else begin
            o1_v_reg <= cmd.out_step;
            o2_v_reg <= o1_v_reg;
            if (o_take) sk_v_reg <= o2_v_reg;
        end
        o1_l_reg <= (rd_reg + 1'b1 == cnt_reg);
        o2_l_reg <= o1_l_reg;
        o2_q_reg <= (25'(d_cur) << 8) + 25'(ln_reg) + 25'd128;
        if (o_take) begin
            sk_d_reg <= 16'(17'h10000 - ((o2_q_reg[24:8] > 17'd32768) ? 17'd32768
                                          : o2_q_reg[24:8]));
            sk_l_reg <= o2_l_reg;
        end
    end

    // Allow a new read only when no item is in flight and the skid register is empty.
    logic [1:0] inflight;
    assign inflight = 2'(o1_v_reg) + 2'(o2_v_reg);

    assign sts.rd_done  = (rd_reg >= cnt_reg);
    assign sts.sum_idle = !s1_v_reg && !s2_v_reg && !s3_v_reg;
    assign sts.ln_done  = (ln_ph_reg == 3'd4);
    assign sts.out_idle = !o1_v_reg && !o2_v_reg && !sk_v_reg;
    assign sts.out_room = (inflight == 2'd0) && !sk_v_reg;

    assign out_valid = sk_v_reg;
    assign out_prob  = sk_d_reg;
    assign out_last  = sk_l_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_LEN)) else $error("count overflow");
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (sk_v_reg && !out_ready) |=> sk_v_reg) else $error("result dropped");
    a_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.sum_step && cmd.out_step)) else $error("two passes at once");
`endif
endmodule

### dv/log_softmax_vector_top_tb.sv
// Self-checking testbench for the log-softmax vector block.
`timescale 1ns / 1ps

// Scoreboard: holds the vector being loaded and the log-probabilities owed.
class log_prob_scoreboard;
    logic signed [15:0] elems[$];
    logic signed [15:0] vec_max;
    logic [16:0] owed_q[$];
    int errors;

    function new();
        vec_max = -16'sd32768;
        errors = 0;
    endfunction

    // Exp term of a distance from the maximum, 16 fraction bits.
    function automatic int unsigned exp_of_dist(int unsigned d);
        int unsigned ei[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
        int unsigned eh[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                                39750, 37341, 35079, 32952, 30957, 29081, 27319, 25664};
        int unsigned el[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
                                63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};
        longint unsigned e;
        if ((d >> 8) >= 12) return 0;
        e = ei[d >> 8];
        e = (e * eh[(d >> 4) & 15] + 32768) >> 16;
        e = (e * el[d & 15] + 32768) >> 16;
        return int'(e);
    endfunction

    // Natural log of a sum with 16 fraction bits, piecewise linear.
    function automatic int unsigned ln_of_sum(int unsigned s);
        int unsigned lt[17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
                                29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};
        int unsigned p, f, i, r;
        longint unsigned diff;
        p = 16;
        if (s < 65536) s = 65536;
        s &= 32'h7FFFFF;
        for (int b = 22; b > 16; b--) begin
            if (((s >> b) & 1) && p == 16) p = b;
        end
        f = (s << (22 - p)) & 32'h3FFFFF;
        i = f >> 18;
        r = f & 32'h3FFFF;
        diff = lt[i + 1] - lt[i];
        return (p - 16) * 45426 + lt[i] + int'((diff * r + 131072) >> 18);
    endfunction

    // Note one accepted element; on the final one, compute the whole vector.
    function void note_request(logic signed [15:0] v, logic last);
        int unsigned sum, lnv, d, q;
        if (elems.size() < 64) begin
            elems.push_back(v);
            if (v > vec_max) vec_max = v;
        end
        if (!last) return;
        sum = 0;
        foreach (elems[j]) sum += exp_of_dist(int'(vec_max) - int'(elems[j]));
        lnv = ln_of_sum(sum);
        foreach (elems[j]) begin
            d = int'(vec_max) - int'(elems[j]);
            q = (d * 256 + lnv + 128) >> 8;
            if (q > 32768) q = 32768;
            owed_q.push_back({(j == elems.size() - 1) ? 1'b1 : 1'b0,
                              16'((65536 - q) & 16'hFFFF)});
        end
        elems.delete();
        vec_max = -16'sd32768;
    endfunction

    // Compare one delivered result with the oldest owed one.
    function void check_result(logic [15:0] lp, logic lst);
        logic [16:0] want;
        if (owed_q.size() == 0) begin
            $display("%0t: unexpected result lp=%0d last=%0b", $time, $signed(lp), lst);
            errors++;
            return;
        end
        want = owed_q.pop_front();
        if (want[15:0] !== lp) begin
            $display("%0t: log_prob expected %0d actual %0d", $time,
                     $signed(want[15:0]), $signed(lp));
            errors++;
        end
        if (want[16] !== lst) begin
            $display("%0t: last_res expected %0b actual %0b", $time, want[16], lst);
            errors++;
        end
    endfunction
endclass

module log_softmax_vector_top_tb;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic m_tuser;

    log_prob_scoreboard sb = new();
    int send_idle_pct = 23;
    int recv_idle_pct = 73;
    int quiet_cycles = 0;
    localparam int QUIET_LIMIT = 20000;

    log_softmax_vector_top uut (.*);

    always #2 aclk = ~aclk;

    // Receiver readiness changes on the falling edge.
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Sample both channels at the rising edge and run the watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tdata, s_tuser);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("log_softmax_vector_top: mismatch");
                $finish;
            end
        end
    end

    // Offer one element and hold it until it is accepted; valid stays high
    // afterwards until the next element or an idle cycle replaces it.
    task automatic send_elem(logic [15:0] v, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tuser <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Send a vector of n elements drawn near a random center, or fully random when spread covers the whole range.
    task automatic send_vector(int n, int spread);
        logic [15:0] center;
        center = $urandom;
        for (int i = 0; i < n; i++) begin
            send_elem((spread >= 65536) ? 16'($urandom)
                      : 16'(center + $urandom_range(spread)), i == n - 1);
        end
    endtask

    // Stop sending and wait until every owed result has come.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    int items;

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: single elements at the extremes, a tie, a wide spread.
        send_elem(16'h7FFF, 1'b1);
        send_elem(16'h8000, 1'b1);
        send_elem(16'h0000, 1'b1);
        send_elem(16'h0100, 1'b0);
        send_elem(16'h0100, 1'b1);
        send_elem(16'h8000, 1'b0);
        send_elem(16'h7FFF, 1'b0);
        send_elem(16'hFFFF, 1'b0);
        send_elem(16'h7F00, 1'b1);
        // Wait for the owed results before going on.
        drain();
        // A full store followed by extra dropped elements, the last one flagged.
        for (int i = 0; i < 66; i++) send_elem(16'($urandom_range(2047)), i == 65);
        drain();

        // Random phases with the three idling profiles.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 73 : 0;
            recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 23 : 0;
            items = 0;
            while (items < 20) begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(60, 64) : $urandom_range(1, 8);
                case ($urandom_range(2))
                    0: send_vector(n, 65536);
                    1: send_vector(n, 4095);
                    default: send_vector(n, 255);
                endcase
                items += n;
            end
            drain();
        end

        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("log_softmax_vector_top: match");
        else
            $display("log_softmax_vector_top: mismatch");
        $finish;
    end
endmodule

### sim.f
rtl/lsv_pkg.sv
rtl/lsv_ctrl.sv
rtl/lsv_dp.sv
rtl/log_softmax_vector_top.sv
dv/log_softmax_vector_top_tb.sv
